// ===== rtl/core/sdud_pkg.sv =====
// ----------------------------------------------------------------------------
// sdud_pkg
// Shared types, constants and the CRC8 byte step for the stepper-driver
// UART datagram master.
// ----------------------------------------------------------------------------
package sdud_pkg;

  localparam int REPLY_BUFFER_BYTES = 32;
  localparam int COUNT_W            = $clog2(REPLY_BUFFER_BYTES + 1);
  localparam int WINDOW_BYTES       = 8;
  localparam int SLOT_W             = $clog2(WINDOW_BYTES);
  localparam int FRAME_BYTES        = 7;
  localparam int IDX_W              = 3;

  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] WRITE_FLAG = 8'h80;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_REPLY = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    action_t     action;
    logic [7:0]  node_address;
    logic [6:0]  reg_address;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;
    logic [31:0] read_value;
  } out_item_t;

  // Control from the dispatcher to reply capture
  typedef struct packed {
    logic       flush;
    logic       arm;
    logic       disarm;
    logic       reply;
    logic [6:0] reg_address;
    logic [7:0] rx_byte;
  } cap_ctl_t;

  // Capture state seen by the dispatcher
  typedef struct packed {
    logic        enough;
    logic        found;
    logic [31:0] value;
  } cap_stat_t;

  // One job for the transmit sequencer
  typedef struct packed {
    logic                 kind;
    logic [FRAME_BYTES-1:0][7:0] frame;
    logic [IDX_W-1:0]     last_idx;
    logic [1:0]           status;
    logic [31:0]          value;
  } tx_cmd_t;

  // One data byte through the CRC: MSB-first register, data fed LSB-first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int b = 0; b < 8; b++) begin
      fb = c[7] ^ data[b];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/sdud_reply_capture.sv =====
// ----------------------------------------------------------------------------
// sdud_reply_capture
// Sliding eight-byte reply window with a ring of running CRCs, one per
// possible frame start, so each window is checked in a single byte step.
// ----------------------------------------------------------------------------
module sdud_reply_capture (
  input  logic               clk,
  input  logic               rst_n,
  input  sdud_pkg::cap_ctl_t ctl,
  output sdud_pkg::cap_stat_t stat
);
  import sdud_pkg::*;

  logic [WINDOW_BYTES-1:0][7:0] window_r;
  logic [WINDOW_BYTES-1:0][7:0] acc_r;
  logic [COUNT_W-1:0]           count_r;
  logic [6:0]                   expected_r;
  logic                         armed_r;
  logic                         found_r;
  logic [31:0]                  value_r;

  logic              take;
  logic              hit;
  logic [SLOT_W-1:0] slot_new;
  logic [SLOT_W-1:0] slot_chk;

  assign slot_new = count_r[SLOT_W-1:0];
  assign slot_chk = slot_new + SLOT_W'(1);
  assign take     = ctl.reply && armed_r && (count_r < COUNT_W'(REPLY_BUFFER_BYTES));

  // window_r[1] becomes the oldest byte once rx_byte shifts in
  assign hit = take && !found_r && (count_r >= COUNT_W'(WINDOW_BYTES - 1)) &&
               (window_r[1] == SYNC_BYTE) && (window_r[3][6:0] == expected_r) &&
               (acc_r[slot_chk] == ctl.rx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      expected_r <= '0;
      armed_r    <= 1'b0;
      found_r    <= 1'b0;
    end else if (ctl.flush) begin
      count_r <= '0;
      found_r <= 1'b0;
      armed_r <= ctl.arm;
      if (ctl.arm) begin
        expected_r <= ctl.reg_address;
      end
    end else if (ctl.disarm) begin
      armed_r <= 1'b0;
    end else if (take) begin
      count_r <= count_r + COUNT_W'(1);
      if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  // Payload: window, running CRCs and the kept value
  always_ff @(posedge clk) begin
    if (take) begin
      window_r <= {ctl.rx_byte, window_r[WINDOW_BYTES-1:1]};
      for (int k = 0; k < WINDOW_BYTES; k++) begin
        // restart the slot for the frame that begins with this byte
        acc_r[k] <= crc8_byte((SLOT_W'(k) == slot_new) ? 8'h00 : acc_r[k], ctl.rx_byte);
      end
      if (hit) begin
        value_r <= {window_r[4], window_r[5], window_r[6], window_r[7]};
      end
    end
  end

  assign stat.enough = (count_r >= COUNT_W'(WINDOW_BYTES));
  assign stat.found  = found_r;
  assign stat.value  = value_r;

  a_found_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> count_r >= COUNT_W'(WINDOW_BYTES))
    else $error("frame kept with fewer than eight reply bytes");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(REPLY_BUFFER_BYTES))
    else $error("reply count past buffer size");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.flush |=> (count_r == '0) && !found_r)
    else $error("request did not flush capture");

endmodule

// ===== rtl/core/sdud_tx_sequencer.sv =====
// ----------------------------------------------------------------------------
// sdud_tx_sequencer
// Holds one request frame or status job and hands its results to the output
// register one per cycle unless stalled, ending each frame with its running CRC.
// ----------------------------------------------------------------------------
module sdud_tx_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sdud_pkg::tx_cmd_t   cmd,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output sdud_pkg::out_item_t out_data
);
  import sdud_pkg::*;

  logic                   busy_r;
  tx_cmd_t                job_r;
  logic [IDX_W-1:0]       idx_r;
  logic [7:0]             crc_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic       advance;
  logic       at_last;
  logic [7:0] byte_cur;
  out_item_t  res_nxt;

  assign advance  = busy_r && (!out_valid_r || out_ready);
  assign at_last  = (idx_r == job_r.last_idx);
  assign can_load = !busy_r || (advance && at_last);

  always_comb begin
    byte_cur = at_last ? crc_r : job_r.frame[idx_r];
    res_nxt  = '0;
    res_nxt.kind = job_r.kind;
    res_nxt.last = at_last;
    if (job_r.kind == KIND_STATUS) begin
      res_nxt.status     = job_r.status;
      res_nxt.read_value = job_r.value;
    end else begin
      res_nxt.tx_byte = byte_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (advance && at_last) begin
        busy_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= cmd;
      idx_r <= '0;
      crc_r <= 8'h00;
    end else if (advance) begin
      idx_r <= idx_r + IDX_W'(1);
      crc_r <= crc8_byte(crc_r, byte_cur);
    end
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.kind |-> out_data_r.last && (out_data_r.tx_byte == 8'h00))
    else $error("status result with transmit byte or without last");

  a_tx_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.kind |-> (out_data_r.status == 2'd0) &&
                                        (out_data_r.read_value == 32'd0))
    else $error("transmit result carries status or value");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy_r || (advance && at_last))
    else $error("job loaded over a job still in progress");

endmodule

// ===== rtl/core/stepper_driver_uart_datagram_top.sv =====
// ----------------------------------------------------------------------------
// stepper_driver_uart_datagram_top
// Master side of a single-wire stepper-driver UART datagram link: builds
// write and read requests, checks reply frames and reports read completion.
// ----------------------------------------------------------------------------
//  channel | ports                         | carries
//  --------+-------------------------------+-----------------------------------
//  input   | in_valid, in_ready, in_data   | request, reply byte or end of reply
//  result  | out_valid, out_ready, out_data| request byte or read status
//
//  A reply byte is taken every cycle and yields no result. A write request
//  yields 8 results, a read 4, an end of reply 1; the transmit sequencer
//  emits one result per cycle unless the output stalls, so a request holds
//  off the next request or end of reply until its final byte moves to the
//  output register, fed from the job register. Reset is synchronous and
//  clears capture and handshake state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stepper_driver_uart_datagram_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdud_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdud_pkg::out_item_t out_data
);
  import sdud_pkg::*;

  logic      accept;
  logic      can_load;
  logic      is_reply;
  logic      load;
  cap_ctl_t  cap_ctl;
  cap_stat_t cap_stat;
  tx_cmd_t   cmd;

  assign is_reply = (in_data.action == ACT_REPLY);
  assign in_ready = is_reply || can_load;
  assign accept   = in_valid && in_ready;
  assign load     = accept && !is_reply;

  always_comb begin
    cap_ctl             = '0;
    cap_ctl.reg_address = in_data.reg_address;
    cap_ctl.rx_byte     = in_data.rx_byte;
    cmd                 = '0;
    cmd.frame[0]        = SYNC_BYTE;
    cmd.frame[1]        = in_data.node_address;
    unique case (in_data.action)
      ACT_WRITE: begin
        cap_ctl.flush = accept;
        cmd.kind      = KIND_TX;
        cmd.frame[2]  = WRITE_FLAG | {1'b0, in_data.reg_address};
        cmd.frame[3]  = in_data.write_value[31:24];
        cmd.frame[4]  = in_data.write_value[23:16];
        cmd.frame[5]  = in_data.write_value[15:8];
        cmd.frame[6]  = in_data.write_value[7:0];
        cmd.last_idx  = IDX_W'(7);
      end
      ACT_READ: begin
        cap_ctl.flush = accept;
        cap_ctl.arm   = 1'b1;
        cmd.kind      = KIND_TX;
        cmd.frame[2]  = {1'b0, in_data.reg_address};
        cmd.last_idx  = IDX_W'(3);
      end
      ACT_REPLY: begin
        cap_ctl.reply = accept;
      end
      ACT_END: begin
        cap_ctl.disarm = accept;
        cmd.kind       = KIND_STATUS;
        cmd.last_idx   = '0;
        // timeout wins over a kept frame
        if (!cap_stat.enough) begin
          cmd.status = ST_TIMEOUT;
        end else if (cap_stat.found) begin
          cmd.status = ST_OK;
          cmd.value  = cap_stat.value;
        end else begin
          cmd.status = ST_INVALID;
        end
      end
      default: begin
        cmd.kind = KIND_TX;
      end
    endcase
  end

  sdud_reply_capture u_capture (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (cap_ctl),
    .stat (cap_stat)
  );

  sdud_tx_sequencer u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .cmd      (cmd),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== tb/sv/datagram_checker.sv =====
// ----------------------------------------------------------------------------
// datagram_checker
// Watches both channels of the datagram master. Each accepted input item is
// run through an independent model of request framing, CRC8 and reply frame
// search. Each accepted result is compared field by field with the oldest
// expected result. Hands the mismatch count and the number of results still
// due to the testbench top.
// ----------------------------------------------------------------------------
module datagram_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sdud_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sdud_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import sdud_pkg::*;

  localparam int MAX_REPORTS = 100;

  out_item_t   due_q[$];
  logic [7:0]  window [8];
  int unsigned taken;
  logic [6:0]  want_reg;
  logic        frame_hit;
  logic [31:0] frame_value;
  logic        armed;
  int          fails;

  // CRC8: register shifts MSB-first, each data byte enters LSB-first
  function automatic logic [7:0] datagram_crc(input logic [7:0] bytes [8], input int n);
    logic [7:0] c;
    logic [7:0] d;
    c = 8'h00;
    for (int i = 0; i < n; i++) begin
      d = bytes[i];
      for (int b = 0; b < 8; b++) begin
        if (c[7] ^ d[0]) c = {c[6:0], 1'b0} ^ CRC_POLY;
        else c = {c[6:0], 1'b0};
        d = d >> 1;
      end
    end
    return c;
  endfunction

  task automatic clear_capture();
    for (int i = 0; i < 8; i++) window[i] = 8'h00;
    taken       = 0;
    frame_hit   = 1'b0;
    frame_value = '0;
  endtask

  task automatic push_result(input logic kind, input logic [7:0] tx, input logic last,
                             input status_t st, input logic [31:0] val);
    out_item_t r;
    r.kind       = kind;
    r.tx_byte    = tx;
    r.last       = last;
    r.status     = st;
    r.read_value = val;
    due_q.push_back(r);
  endtask

  task automatic predict_datagram(input in_item_t it);
    logic [7:0] req [8];
    int         n;
    case (it.action)
      ACT_WRITE, ACT_READ: begin
        clear_capture();
        req[0] = SYNC_BYTE;
        req[1] = it.node_address;
        if (it.action == ACT_WRITE) begin
          req[2] = {1'b0, it.reg_address} | WRITE_FLAG;
          req[3] = it.write_value[31:24];
          req[4] = it.write_value[23:16];
          req[5] = it.write_value[15:8];
          req[6] = it.write_value[7:0];
          req[7] = datagram_crc(req, 7);
          n      = 8;
          armed  = 1'b0;
        end else begin
          req[2]   = {1'b0, it.reg_address};
          req[3]   = datagram_crc(req, 3);
          n        = 4;
          armed    = 1'b1;
          want_reg = it.reg_address;
        end
        for (int i = 0; i < n; i++)
          push_result(KIND_TX, req[i], i == n - 1, ST_OK, '0);
      end
      ACT_REPLY: begin
        // drop bytes while disarmed or once the buffer is full
        if (armed && taken < REPLY_BUFFER_BYTES) begin
          for (int i = 0; i < 7; i++) window[i] = window[i + 1];
          window[7] = it.rx_byte;
          taken++;
          if (taken >= 8 && !frame_hit && window[0] == SYNC_BYTE &&
              window[2][6:0] == want_reg && datagram_crc(window, 7) == window[7]) begin
            frame_hit   = 1'b1;
            frame_value = {window[3], window[4], window[5], window[6]};
          end
        end
      end
      default: begin
        if (taken < 8) push_result(KIND_STATUS, 8'h00, 1'b1, ST_TIMEOUT, '0);
        else if (frame_hit) push_result(KIND_STATUS, 8'h00, 1'b1, ST_OK, frame_value);
        else push_result(KIND_STATUS, 8'h00, 1'b1, ST_INVALID, '0);
        armed = 1'b0;
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (fails < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing due: kind %0d tx %02h status %0d",
                                got.kind, got.tx_byte, got.status));
      return;
    end
    want = due_q.pop_front();
    compare_field("kind", got.kind, want.kind);
    compare_field("tx_byte", got.tx_byte, want.tx_byte);
    compare_field("last", got.last, want.last);
    compare_field("status", got.status, want.status);
    compare_field("read_value", got.read_value, want.read_value);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      due_q.delete();
      clear_capture();
      want_reg = '0;
      armed    = 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) predict_datagram(in_data);
    end
    outstanding <= due_q.size();
    mismatches  <= fails;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the stepper-driver UART datagram master: directed
// requests and reply frames, then random read transactions, writes and noise
// under random idling on both sides, a long output stall and drain pauses.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdud_pkg::*;

  localparam int IDLE_PCT     = 34;
  localparam int STALL_CYCLES = 120;
  localparam int DRAIN_CYCLES = 4;

  localparam int FRAME_GOOD     = 0;
  localparam int FRAME_BAD_SYNC = 1;
  localparam int FRAME_BAD_REG  = 2;
  localparam int FRAME_BAD_CRC  = 3;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        mismatches;
  int        outstanding;

  logic idle_on = 1'b1;
  int   stall_asks = 0;
  int   stalls_served = 0;
  int   sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stepper_driver_uart_datagram_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  datagram_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random back-pressure, always ready with idling off, or a long hold-off when asked
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_asks != stalls_served) begin
        stalls_served++;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else if (idle_on) begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t blank_item(input action_t act);
    in_item_t it;
    it.action       = act;
    it.node_address = 8'($urandom);
    it.reg_address  = 7'($urandom);
    it.write_value  = $urandom;
    it.rx_byte      = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_write(input logic [7:0] node, input logic [6:0] reg_no,
                            input logic [31:0] val);
    in_item_t it;
    it = blank_item(ACT_WRITE);
    it.node_address = node;
    it.reg_address  = reg_no;
    it.write_value  = val;
    send_item(it);
  endtask

  task automatic send_read(input logic [7:0] node, input logic [6:0] reg_no);
    in_item_t it;
    it = blank_item(ACT_READ);
    it.node_address = node;
    it.reg_address  = reg_no;
    send_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it = blank_item(ACT_REPLY);
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_end();
    send_item(blank_item(ACT_END));
  endtask

  task automatic send_noise_bytes(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom));
  endtask

  // Reply frame; a fault spoils one field while the rest stays consistent
  task automatic send_frame(input logic [6:0] reg_no, input logic [31:0] val,
                            input int fault);
    logic [7:0] fr [8];
    logic [7:0] crc;
    fr[0] = SYNC_BYTE;
    fr[1] = 8'($urandom);
    fr[2] = {1'($urandom_range(1)), reg_no};
    fr[3] = val[31:24];
    fr[4] = val[23:16];
    fr[5] = val[15:8];
    fr[6] = val[7:0];
    if (fault == FRAME_BAD_SYNC) fr[0] ^= 8'($urandom_range(1, 255));
    if (fault == FRAME_BAD_REG) fr[2][6:0] ^= 7'($urandom_range(1, 127));
    crc = 8'h00;
    for (int i = 0; i < 7; i++) crc = crc8_byte(crc, fr[i]);
    fr[7] = crc;
    if (fault == FRAME_BAD_CRC) fr[7] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < 8; i++) send_byte(fr[i]);
  endtask

  // Hold the input until every due result has gone, then let reply bytes settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic read_transaction();
    logic [6:0] reg_no;
    int         pick;
    reg_no = 7'($urandom);
    pick   = $urandom_range(99);
    send_read(8'($urandom), reg_no);
    if (pick < 50) begin
      send_noise_bytes($urandom_range(3));
      send_frame(reg_no, $urandom, FRAME_GOOD);
      // a later good frame must not replace the first
      if ($urandom_range(99) < 30) send_frame(reg_no, $urandom, FRAME_GOOD);
      send_noise_bytes($urandom_range(2));
    end else if (pick < 65) begin
      send_noise_bytes($urandom_range(2));
      send_frame(reg_no, $urandom, $urandom_range(FRAME_BAD_SYNC, FRAME_BAD_CRC));
      send_noise_bytes($urandom_range(2));
    end else if (pick < 75) begin
      send_noise_bytes($urandom_range(7));
    end else if (pick < 85) begin
      // frame ends at or beyond the buffer limit
      send_noise_bytes($urandom_range(24, 30));
      send_frame(reg_no, $urandom, FRAME_GOOD);
    end else begin
      send_noise_bytes($urandom_range(8, 20));
    end
    if ($urandom_range(99) < 90) send_end();
  endtask

  task automatic random_step();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      read_transaction();
    end else if (pick < 75) begin
      send_write(8'($urandom), 7'($urandom), $urandom);
      if ($urandom_range(99) < 30) send_end();
    end else begin
      for (int i = $urandom_range(1, 4); i > 0; i--)
        send_item(blank_item(action_t'($urandom_range(3))));
    end
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_write(8'h00, 7'h00, 32'h0000_0000);
    send_write(8'hFF, 7'h7F, 32'hFFFF_FFFF);
    send_read(8'hFF, 7'h7F);
    send_end();
    send_end();
    send_byte(8'hA5);
    send_read(8'h00, 7'h00);
    send_frame(7'h00, 32'hFFFF_FFFF, FRAME_GOOD);
    send_end();
    send_write(8'($urandom), 7'($urandom), $urandom);
    send_end();
    send_read(8'($urandom), 7'h2A);
    send_noise_bytes(3);
    send_end();
    drain();

    // fill the block while the result side holds off
    stall_asks++;
    for (int i = 0; i < 12; i++) send_write(8'($urandom), 7'($urandom), $urandom);
    drain();

    while (sent < 170) random_step();
    idle_on = 1'b0;
    while (sent < 270) random_step();
    drain();
    idle_on = 1'b1;
    while (sent < 350) random_step();
    drain();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
